[rtl/ira_pkg.sv]
// ----------------------------------------------------------------------------
// ira_pkg: shared types and constants of the radix ASCII converter
// Holds the character codes, radix limits, the controller state type and the
// control and status bundles passed to the digit lane array.
// ----------------------------------------------------------------------------
package ira_pkg;

   // Field widths fixed by the channel payloads.
   localparam int VALUE_BITS = 64;
   localparam int RADIX_BITS = 6;
   localparam int DIGIT_BITS = 6;
   localparam int CHAR_BITS  = 7;

   // Radix limits and the reset base.
   localparam logic [RADIX_BITS-1:0] RADIX_MIN    = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX    = 6'd36;
   localparam logic [RADIX_BITS-1:0] RADIX_SIGNED = 6'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_RESET  = 6'd10;

   // ASCII codes.
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO   = 7'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER  = 7'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS  = 7'h2D;
   localparam logic [DIGIT_BITS-1:0] DIGIT_TEN  = 6'd10;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_ALIGN,
      ST_EMIT
   } ira_state_type;

   // Operations on the digit lane array.
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_CLEAR,
      OP_CONVERT,
      OP_ALIGN,
      OP_EMIT
   } ira_op_type;

   typedef struct packed {
      ira_op_type op;
      logic       bit_in;
   } ira_ctrl_type;

   typedef struct packed {
      logic                  aligned;
      logic [DIGIT_BITS-1:0] top_digit;
   } ira_status_type;

   // Map one digit value to its ASCII character.
   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] ch;
      if (d < DIGIT_TEN) begin
         ch = CHAR_ZERO + CHAR_BITS'(d);
      end else begin
         ch = CHAR_LOWER + CHAR_BITS'(d - DIGIT_TEN);
      end
      return ch;
   endfunction

endpackage

[rtl/ira_ifs.sv]
// ----------------------------------------------------------------------------
// ira_ifs: channel interfaces of the radix ASCII converter
// Request, response and register write channels, each with valid and ready.
// ----------------------------------------------------------------------------

// Input channel: one signed integer per item.
interface ira_req_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// Result channel: one ASCII character per item.
interface ira_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] character;
   logic       last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

// Register write channel: the radix.
interface ira_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] radix;

   modport source (output valid, output radix, input ready);
   modport sink   (input valid, input radix, output ready);
endinterface

[rtl/integer_to_radix_ascii_unit.sv]
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_unit: signed integer to ASCII text in base 2 to 36
// Converts one integer per item into its digits, most significant first.
// ----------------------------------------------------------------------------
// Usage:
// req_ch carries one signed integer per item; only its low VALUE_WIDTH bits
// are used. rsp_ch returns one ASCII character per item, with last set on
// the final character of the number. csr_ch writes the radix (reset 10) and
// is always ready; write it only while the unit is idle.
// In base ten a negative number starts with a minus sign; in other bases the
// bit pattern is converted as unsigned. Zero gives a single '0'. A radix
// outside 2 to 36 swallows the item and returns nothing.
// Sequence: after an item is accepted the digit lanes take in its bits, one
// input bit per cycle, then shift the string up in steps of eight lanes and
// then of one lane until the leading digit sits in the top lane. Characters
// then leave at one per cycle while the receiver is ready.
// The next item is taken once the last character sits in the output register.
// A stalled receiver holds the output register and pauses the shift-out.
// Reset returns the controller to idle and the radix to ten.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_unit #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   ira_req_if.sink   req_ch,
   ira_rsp_if.source rsp_ch,
   ira_csr_if.sink   csr_ch
);
   import ira_pkg::*;

   localparam int BCW = $clog2(VALUE_WIDTH);
   localparam int CW  = $clog2(VALUE_WIDTH + 1);
   localparam logic [BCW-1:0] LAST_BIT = BCW'(VALUE_WIDTH - 1);
   localparam logic [CW-1:0]  ONE_C    = CW'(1);

   ira_state_type state_ff, state_in;

   logic [RADIX_BITS-1:0]  radix_ff, radix_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BCW-1:0]         bit_cnt_ff, bit_cnt_in;
   logic                   sign_pend_ff, sign_pend_in;
   logic [CW-1:0]          remain_ff, remain_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]   char_ff, char_in;
   logic                   last_ff, last_in;

   logic                   radix_ok;
   logic                   req_fire;
   logic                   out_free;
   logic [VALUE_WIDTH-1:0] req_bits;
   logic                   req_neg;
   logic                   req_ready_w;
   ira_ctrl_type           arr_ctrl;
   ira_status_type         arr_status;
   logic [CW-1:0]          digit_count;

   // Digit lanes.
   ira_digit_array #(
      .NDIG (VALUE_WIDTH)
   ) u_digits (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (arr_ctrl),
      .radix       (radix_ff),
      .status      (arr_status),
      .digit_count (digit_count)
   );

   // Handshake helpers.
   assign radix_ok = (radix_ff >= RADIX_MIN) && (radix_ff <= RADIX_MAX);
   assign req_fire = req_ch.valid && req_ready_w;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_bits = req_ch.value[VALUE_WIDTH-1:0];
   assign req_neg  = (radix_ff == RADIX_SIGNED) && req_bits[VALUE_WIDTH-1];

   // Register write channel.
   assign csr_ch.ready = 1'b1;
   assign radix_in     = csr_ch.valid ? csr_ch.radix : radix_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && radix_ok) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (bit_cnt_ff == LAST_BIT) begin
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            if (arr_status.aligned || digit_count == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && !sign_pend_ff && remain_ff <= ONE_C) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Controller outputs.
   always_comb begin
      req_ready_w     = 1'b0;
      arr_ctrl.op     = OP_HOLD;
      arr_ctrl.bit_in = mag_ff[VALUE_WIDTH-1];
      unique case (state_ff)
         ST_IDLE: begin
            req_ready_w = 1'b1;
            if (req_fire && radix_ok) begin
               arr_ctrl.op = OP_CLEAR;
            end
         end
         ST_CONV: begin
            arr_ctrl.op = OP_CONVERT;
         end
         ST_ALIGN: begin
            arr_ctrl.op = OP_ALIGN;
         end
         ST_EMIT: begin
            if (out_free && !sign_pend_ff && remain_ff != '0) begin
               arr_ctrl.op = OP_EMIT;
            end
         end
         default: begin
         end
      endcase
   end

   // Datapath and output register next values.
   always_comb begin
      mag_in       = mag_ff;
      bit_cnt_in   = bit_cnt_ff;
      sign_pend_in = sign_pend_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mag_in       = req_neg ? (~req_bits + VALUE_WIDTH'(1)) : req_bits;
               bit_cnt_in   = '0;
               sign_pend_in = req_neg;
            end
         end
         ST_CONV: begin
            mag_in     = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + BCW'(1);
         end
         ST_ALIGN: begin
            remain_in = digit_count;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sign_pend_ff) begin
                  char_in      = CHAR_MINUS;
                  last_in      = 1'b0;
                  sign_pend_in = 1'b0;
               end else if (remain_ff == '0) begin
                  // Zero value: a single '0'.
                  char_in = CHAR_ZERO;
                  last_in = 1'b1;
               end else begin
                  char_in   = digit_char(arr_status.top_digit);
                  last_in   = (remain_ff == ONE_C);
                  remain_in = remain_ff - ONE_C;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         rsp_valid_ff <= 1'b0;
         sign_pend_ff <= 1'b0;
         bit_cnt_ff   <= '0;
         remain_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
         sign_pend_ff <= sign_pend_in;
         bit_cnt_ff   <= bit_cnt_in;
         remain_ff    <= remain_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   // Port drives.
   assign req_ch.ready     = req_ready_w;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.character = char_ff;
   assign rsp_ch.last      = last_ff;

`ifndef SYNTHESIS
   // A digit shifted out of the top lane is always below the radix.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (arr_ctrl.op == OP_EMIT) |-> (arr_status.top_digit < radix_ff))
      else $error("digit out of range for the radix");

   // The minus sign never ends a number.
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && char_ff == CHAR_MINUS) |-> !last_ff)
      else $error("minus sign flagged as last character");

   // Conversion only moves on to alignment.
   a_conv_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |=> (state_ff == ST_CONV || state_ff == ST_ALIGN))
      else $error("conversion left for an unexpected state");
`endif

endmodule

[rtl/ira_digit_array.sv]
// ----------------------------------------------------------------------------
// ira_digit_array: digit lanes of the radix converter
// Holds one digit per lane, least significant in lane 0. Each conversion step
// doubles the whole digit string and adds one input bit, with the carries
// between lanes resolved by a single wide add. After conversion the string is
// shifted up until its leading digit sits in the top lane, then shifted out.
// ----------------------------------------------------------------------------
module ira_digit_array #(
   parameter int NDIG = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ira_pkg::ira_ctrl_type                ctrl,
   input  logic [ira_pkg::RADIX_BITS-1:0]       radix,
   output ira_pkg::ira_status_type              status,
   output logic [$clog2(NDIG+1)-1:0]            digit_count
);
   import ira_pkg::*;

   localparam int CW         = $clog2(NDIG + 1);
   localparam int ALIGN_STEP = 8;
   localparam logic [CW-1:0] ALIGN_STEP_C = CW'(ALIGN_STEP);
   localparam logic [CW-1:0] NDIG_C       = CW'(NDIG);

   logic [DIGIT_BITS-1:0] lane_ff [NDIG];
   logic [DIGIT_BITS-1:0] lane_in [NDIG];
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         gap_ff, gap_in;

   logic [NDIG-1:0]       gen;
   logic [NDIG-1:0]       prop;
   logic [NDIG-1:0]       gen_or_prop;
   logic [NDIG:0]         sum;
   logic [NDIG:0]         carry;
   logic [DIGIT_BITS-1:0] conv_lane [NDIG];

   // A lane carries out when twice its digit plus the incoming carry reaches
   // the radix. It generates on its own at 2d >= r and passes the carry on
   // when 2d + 1 == r.
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         gen[i]  = ({lane_ff[i], 1'b0} >= {1'b0, radix});
         prop[i] = ({lane_ff[i], 1'b1} == {1'b0, radix});
      end
   end

   // Carry chain as an adder: carry into bit i is sum ^ a ^ b at that bit.
   assign gen_or_prop = gen | prop;
   assign sum = {1'b0, gen_or_prop} + {1'b0, gen} + {{NDIG{1'b0}}, ctrl.bit_in};

   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         carry[i] = sum[i] ^ gen_or_prop[i] ^ gen[i];
      end
      carry[NDIG] = sum[NDIG];
   end

   // Per-lane doubling step with the carry applied.
   always_comb begin
      logic [DIGIT_BITS:0] twice;
      for (int i = 0; i < NDIG; i++) begin
         twice = {lane_ff[i], carry[i]};
         if (carry[i+1]) begin
            twice = twice - {1'b0, radix};
         end
         conv_lane[i] = twice[DIGIT_BITS-1:0];
      end
   end

   // Next lane contents and counters for each operation.
   always_comb begin
      lane_in  = lane_ff;
      count_in = count_ff;
      gap_in   = gap_ff;
      case (ctrl.op)
         OP_CLEAR: begin
            for (int i = 0; i < NDIG; i++) begin
               lane_in[i] = '0;
            end
            count_in = '0;
            gap_in   = NDIG_C;
         end
         OP_CONVERT: begin
            lane_in  = conv_lane;
            count_in = count_ff + CW'(carry[count_ff]);
            gap_in   = gap_ff - CW'(carry[count_ff]);
         end
         OP_ALIGN: begin
            if (gap_ff >= ALIGN_STEP_C) begin
               for (int i = 0; i < NDIG; i++) begin
                  lane_in[i] = (i >= ALIGN_STEP) ? lane_ff[i-ALIGN_STEP] : '0;
               end
               gap_in = gap_ff - ALIGN_STEP_C;
            end else if (gap_ff != '0) begin
               for (int i = 0; i < NDIG; i++) begin
                  lane_in[i] = (i >= 1) ? lane_ff[i-1] : '0;
               end
               gap_in = gap_ff - CW'(1);
            end
         end
         OP_EMIT: begin
            for (int i = 0; i < NDIG; i++) begin
               lane_in[i] = (i >= 1) ? lane_ff[i-1] : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Digit lanes hold payload only.
   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
   end

   // Digit count and alignment gap.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         gap_ff   <= NDIG_C;
      end else begin
         count_ff <= count_in;
         gap_ff   <= gap_in;
      end
   end

   assign status.aligned   = (gap_ff == '0);
   assign status.top_digit = lane_ff[NDIG-1];
   assign digit_count      = count_ff;

endmodule

[verif/radix_text_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_text_checker: prediction and comparison for the radix ASCII converter
// Watches the register, input and result channels. Each accepted integer is
// turned into its expected characters in the current base, and each accepted
// character is compared against the oldest one still waiting.
// ----------------------------------------------------------------------------
module radix_text_checker #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic clock,
   input  logic reset,
   ira_req_if   req_ch,
   ira_rsp_if   rsp_ch,
   ira_csr_if   csr_ch,
   output int   chars_pending,
   output int   mismatch_count
);

   import ira_pkg::*;

   typedef struct packed {
      logic [CHAR_BITS-1:0] character;
      logic                 last;
   } text_char_type;

   // Digit values index straight into this alphabet.
   localparam string DIGIT_ALPHABET = "0123456789abcdefghijklmnopqrstuvwxyz";

   text_char_type         expected_chars[$];
   logic [RADIX_BITS-1:0] base_reg;

   // One line per mismatch, and count it.
   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatch_count++;
   endtask

   // Queue up the text of one integer in the current base.
   function automatic void predict_text(input logic [63:0] value);
      logic [63:0]           width_mask;
      logic [63:0]           bits;
      logic [63:0]           magnitude;
      logic [DIGIT_BITS-1:0] digit_stack[64];
      int                    digit_count;
      logic                  negative;
      text_char_type         ch;
      width_mask  = {64{1'b1}} >> (64 - VALUE_WIDTH);
      bits        = value & width_mask;
      digit_count = 0;

      // A base out of range swallows the item.
      if (base_reg < RADIX_MIN || base_reg > RADIX_MAX) begin
         return;
      end

      if (bits == 64'd0) begin
         ch.character = CHAR_ZERO;
         ch.last      = 1'b1;
         expected_chars.push_back(ch);
         return;
      end

      // Only base ten reads the pattern as signed; the magnitude is unsigned,
      // so the most negative value comes out whole.
      negative  = (base_reg == RADIX_SIGNED) && bits[VALUE_WIDTH-1];
      magnitude = negative ? ((~bits + 64'd1) & width_mask) : bits;

      while (magnitude != 64'd0) begin
         digit_stack[digit_count] = DIGIT_BITS'(magnitude % base_reg);
         magnitude = magnitude / base_reg;
         digit_count++;
      end

      if (negative) begin
         ch.character = CHAR_MINUS;
         ch.last      = 1'b0;
         expected_chars.push_back(ch);
      end

      // Most significant digit first.
      for (int i = digit_count - 1; i >= 0; i--) begin
         ch.character = CHAR_BITS'(DIGIT_ALPHABET[int'(digit_stack[i])]);
         ch.last      = (i == 0);
         expected_chars.push_back(ch);
      end
   endfunction

   // Sample all three channels at the clock edge.
   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         base_reg = RADIX_RESET;
         expected_chars.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("character %h (last %b) with nothing expected",
                                         rsp_ch.character, rsp_ch.last));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_ch.character !== want.character) begin
                  report_mismatch($sformatf("character got %h expected %h",
                                            rsp_ch.character, want.character));
               end
               if (rsp_ch.last !== want.last) begin
                  report_mismatch($sformatf("last got %b expected %b on character %h",
                                            rsp_ch.last, want.last, want.character));
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_text(req_ch.value);
         end
         if (csr_ch.valid && csr_ch.ready) begin
            base_reg = csr_ch.radix;
         end
      end
      chars_pending <= expected_chars.size();
   end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the radix ASCII converter
// Runs a directed set of integers over several bases, including the invalid
// ones, then random integers under a series of random bases with varying
// sender and receiver idling. The checker beside the unit does the comparing.
// ----------------------------------------------------------------------------
module tb;

   import ira_pkg::*;

   localparam int VALUE_WIDTH   = 64;
   localparam int RANDOM_ITEMS  = 140;
   localparam int SETTLE_CYCLES = 2 * VALUE_WIDTH + 32;
   localparam int HOLD_AT       = 110;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 1000000;

   localparam logic [63:0] VALUE_MOST_NEG = 64'h8000_0000_0000_0000;
   localparam logic [63:0] VALUE_MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] VALUE_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic hold_request = 1'b0;
   int   sender_idle_pct = 20;
   int   receiver_idle_pct = 82;
   int   chars_pending;
   int   mismatch_count;
   int   cycle_count = 0;

   ira_req_if req_ch ();
   ira_rsp_if rsp_ch ();
   ira_csr_if csr_ch ();

   integer_to_radix_ascii_unit #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   radix_text_checker #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .chars_pending (chars_pending),
      .mismatch_count(mismatch_count)
   );

   always #5 clock = ~clock;

   // Watchdog on the whole run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request <= 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
      end
   end

   // Offer one integer, with a random gap first, and wait for it to be taken.
   task automatic send_value(input logic [63:0] value);
      while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Stop offering, wait for every expected character, then let the unit
   // finish any item that produces no text.
   task automatic drain_and_settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (chars_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_radix(input logic [RADIX_BITS-1:0] base);
      csr_ch.valid <= 1'b1;
      csr_ch.radix <= base;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Idling follows the progress of the random part.
   task automatic set_idle_mode(input int sent);
      if (sent < 50) begin
         sender_idle_pct   = 20;
         receiver_idle_pct <= 82;
      end else if (sent < 100) begin
         sender_idle_pct   = 82;
         receiver_idle_pct <= 20;
      end else begin
         sender_idle_pct   = 0;
         receiver_idle_pct <= 0;
      end
   endtask

   // Mix of full-width patterns, small numbers, powers of two and extremes.
   function automatic logic [63:0] random_value();
      logic [63:0] full;
      int          shift;
      logic [63:0] result;
      full  = {$urandom, $urandom};
      shift = $urandom_range(63, 0);
      case ($urandom_range(7, 0))
         0: result = 64'($urandom_range(999, 0));
         1: result = -64'($urandom_range(999, 1));
         2: result = (64'd1 << shift) - 64'($urandom_range(2, 0));
         3: result = full >> shift;
         4: begin
            case ($urandom_range(3, 0))
               0: result = 64'd0;
               1: result = VALUE_ALL_ONES;
               2: result = VALUE_MOST_NEG;
               default: result = VALUE_MOST_POS;
            endcase
         end
         default: result = full;
      endcase
      return result;
   endfunction

   // Mostly valid bases, the extremes often, an invalid one now and then.
   function automatic logic [RADIX_BITS-1:0] pick_radix();
      logic [RADIX_BITS-1:0] base;
      case ($urandom_range(9, 0))
         0: base = RADIX_MIN;
         1: base = RADIX_MAX;
         2, 3: base = RADIX_SIGNED;
         4: begin
            if ($urandom_range(1, 0) == 1) begin
               base = RADIX_BITS'($urandom_range(1, 0));
            end else begin
               base = RADIX_BITS'($urandom_range(63, 37));
            end
         end
         default: base = RADIX_BITS'($urandom_range(36, 2));
      endcase
      return base;
   endfunction

   // Main stimulus.
   initial begin
      logic [RADIX_BITS-1:0] base;
      logic                  base_ok;
      int                    sent;
      int                    chunk;
      req_ch.valid <= 1'b0;
      req_ch.value <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.radix <= '0;
      reset        <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: base ten from reset, signs, zero and both extremes.
      send_value(64'd0);
      send_value(64'd1);
      send_value(VALUE_ALL_ONES);
      send_value(64'd9);
      send_value(64'd10);
      send_value(-64'd10);
      send_value(VALUE_MOST_POS);
      send_value(VALUE_MOST_NEG);
      send_value(64'd1234567890);
      send_value(-64'd987654321);

      // Highest base: the top digit, the first carry and negatives as unsigned patterns.
      drain_and_settle();
      write_radix(RADIX_MAX);
      send_value(64'd35);
      send_value(64'd36);
      send_value(VALUE_ALL_ONES);
      send_value(VALUE_MOST_NEG);
      send_value(64'd0);

      // Lowest base: the longest texts.
      drain_and_settle();
      write_radix(RADIX_MIN);
      send_value(64'd1);
      send_value(64'd2);
      send_value(VALUE_ALL_ONES);
      send_value(VALUE_MOST_NEG);

      drain_and_settle();
      write_radix(6'd16);
      send_value(64'h0123_4567_89AB_CDEF);
      send_value(64'hFEDC_BA98_7654_3210);

      // Bases out of range produce no text.
      drain_and_settle();
      write_radix(6'd0);
      send_value(64'd5);
      drain_and_settle();
      write_radix(6'd1);
      send_value(64'd3);
      drain_and_settle();
      write_radix(6'd37);
      send_value(64'd4);
      drain_and_settle();
      write_radix(6'd63);
      send_value(VALUE_ALL_ONES);

      // Random part: phases of random bases with random integers.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         drain_and_settle();
         base    = pick_radix();
         base_ok = (base >= RADIX_MIN) && (base <= RADIX_MAX);
         write_radix(base);
         chunk = base_ok ? $urandom_range(20, 8) : $urandom_range(3, 1);
         for (int i = 0; i < chunk; i++) begin
            set_idle_mode(sent);
            if (base_ok && sent == HOLD_AT) begin
               hold_request <= 1'b1;
            end
            send_value(random_value());
            if (base_ok) begin
               sent++;
            end
         end
      end

      drain_and_settle();
      if (mismatch_count == 0 && chars_pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
